// ===== rtl/pvar_pkg.sv =====
// Shared types, constants and the exp2 root constant function for the power variogram evaluator.
`default_nettype none
package pvar_pkg;

	localparam int LOG_BITS  = 24;
	localparam int SQRT_STEPS = 32;
	localparam int SILL_WHOLE = 9999;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_NUGGET = 2'd0,
		REG_SLOPE  = 2'd1,
		REG_POWER  = 2'd2
	} cfg_reg_t;

	// beat between square root cells
	typedef struct packed {
		logic        valid;
		logic [63:0] rem;
		logic [63:0] root;
	} sqrt_beat_t;

	// beat between log2 cells
	typedef struct packed {
		logic                valid;
		logic                zero;
		logic [4:0]          expo;
		logic [31:0]         mant;
		logic [LOG_BITS-1:0] frac;
	} log_beat_t;

	// beat between exp2 cells
	typedef struct packed {
		logic                valid;
		logic                zero;
		logic signed [7:0]   whole;
		logic [LOG_BITS-1:0] frac;
		logic [30:0]         mant;
	} exp_beat_t;

	// floored integer square root, elaboration only
	function automatic logic [63:0] isqrt_const(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = val;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-k) in Q1.30, k from 1
	function automatic logic [63:0] root_val(input int k);
		logic [63:0] r;
		r = isqrt_const(64'd1 << 61);
		for (int i = 1; i < k; i++) begin
			r = isqrt_const(r << 30);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pvar_sqrt_cell.sv =====
// One result bit of the pipelined 64-bit integer square root.
`default_nettype none
module pvar_sqrt_cell #(
	parameter int STEP = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire pvar_pkg::sqrt_beat_t beat_in,
	output pvar_pkg::sqrt_beat_t     beat_out
);

	localparam logic [63:0] BIT_W = 64'd1 << (62 - 2 * STEP);

	logic [63:0] trial;
	logic [63:0] rem_nxt;
	logic [63:0] root_nxt;
	logic        valid_q;
	logic [63:0] rem_q;
	logic [63:0] root_q;

	// restoring step
	always_comb begin
		trial = beat_in.root + BIT_W;
		if (beat_in.rem >= trial) begin
			rem_nxt  = beat_in.rem - trial;
			root_nxt = (beat_in.root >> 1) + BIT_W;
		end else begin
			rem_nxt  = beat_in.rem;
			root_nxt = beat_in.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_nxt;
			root_q <= root_nxt;
		end
	end

	assign beat_out = '{valid: valid_q, rem: rem_q, root: root_q};

endmodule
`default_nettype wire

// ===== rtl/pvar_log_cell.sv =====
// One fraction bit of log2 by squaring the normalized mantissa.
`default_nettype none
module pvar_log_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire pvar_pkg::log_beat_t beat_in,
	output pvar_pkg::log_beat_t     beat_out
);

	logic [63:0] sq;
	logic [32:0] sq_sh;
	logic        bit_nxt;
	logic [31:0] mant_nxt;
	logic        valid_q;
	logic        zero_q;
	logic [4:0]  expo_q;
	logic [31:0] mant_q;
	logic [pvar_pkg::LOG_BITS-1:0] frac_q;

	// square, renormalize when it reaches two
	always_comb begin
		sq       = 64'(beat_in.mant) * 64'(beat_in.mant);
		sq_sh    = sq[63:31];
		bit_nxt  = sq_sh[32];
		mant_nxt = bit_nxt ? sq_sh[32:1] : sq_sh[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= beat_in.zero;
			expo_q <= beat_in.expo;
			mant_q <= mant_nxt;
			frac_q <= {beat_in.frac[pvar_pkg::LOG_BITS-2:0], bit_nxt};
		end
	end

	assign beat_out = '{valid: valid_q, zero: zero_q, expo: expo_q, mant: mant_q,
		frac: frac_q};

endmodule
`default_nettype wire

// ===== rtl/pvar_exp_cell.sv =====
// One fraction bit of exp2: conditional multiply by a fixed root of two.
`default_nettype none
module pvar_exp_cell #(
	parameter int K = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire pvar_pkg::exp_beat_t beat_in,
	output pvar_pkg::exp_beat_t     beat_out
);

	localparam logic [63:0] ROOT_FULL = pvar_pkg::root_val(K);
	localparam logic [30:0] ROOT      = ROOT_FULL[30:0];

	logic [61:0] prod;
	logic [30:0] mant_nxt;
	logic        valid_q;
	logic        zero_q;
	logic signed [7:0] whole_q;
	logic [pvar_pkg::LOG_BITS-1:0] frac_q;
	logic [30:0] mant_q;

	always_comb begin
		prod     = 62'(beat_in.mant) * 62'(ROOT);
		mant_nxt = beat_in.frac[pvar_pkg::LOG_BITS-K] ? prod[60:30] : beat_in.mant;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q  <= beat_in.zero;
			whole_q <= beat_in.whole;
			frac_q  <= beat_in.frac;
			mant_q  <= mant_nxt;
		end
	end

	assign beat_out = '{valid: valid_q, zero: zero_q, whole: whole_q, frac: frac_q,
		mant: mant_q};

endmodule
`default_nettype wire

// ===== rtl/power_variogram_eval_unit.sv =====
// Top level of the power-law variogram evaluator: cell chains, scaling and output register.
// Usage:
//   Input stream s_axis carries one separation (offset_x, offset_y) per beat,
//   both signed with FRAC_BITS fraction bits. Output stream m_axis carries
//   semivariance = nugget + slope*h^p and covariance_out = 9999 - slope*h^p,
//   signed 64-bit with FRAC_BITS fraction bits, saturated, plus an overflow
//   flag. The cfg port writes nugget (0), slope (1) and exponent (2); the user
//   must write them only while idle, which the block does not enforce.
//   Throughput: one beat per cycle when not stalled. The chain is 32 square
//   root cells, 24 log2 squaring cells and 24 exp2 multiply cells, plus
//   squaring, sum, normalize, exponent product, shift and two slope multiply
//   stages and the output register. The whole chain advances together; a
//   stalled receiver holds the output register and freezes the chain, so
//   s_axis_tready drops only while a result waits unaccepted.
//   Reset clears all valid bits and loads nugget 0.2, slope 1.0, exponent 1.0.
`default_nettype none
module power_variogram_eval_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [63:0]  s_axis_tdata,   // offset_x[31:0], offset_y[63:32]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [135:0]      m_axis_tdata,   // semivariance[63:0], covariance_out[127:64],
	                                          // overflow_flag[128], zero pad
	input  wire logic         cfg_wr_en,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata
);

	localparam int NL = pvar_pkg::LOG_BITS;
	localparam int NS = pvar_pkg::SQRT_STEPS;
	localparam logic [63:0] SILL_FIX = 64'(pvar_pkg::SILL_WHOLE) << FRAC_BITS;
	localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] SMIN = {1'b1, 63'd0};

	logic adv;

	// configuration registers
	logic [31:0] nugget_q;
	logic [31:0] slope_q;
	logic [15:0] power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nugget_q <= 32'd13107;
			slope_q  <= 32'd65536;
			power_q  <= 16'd32768;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pvar_pkg::REG_NUGGET: nugget_q <= cfg_wdata;
				pvar_pkg::REG_SLOPE:  slope_q  <= cfg_wdata;
				pvar_pkg::REG_POWER:  power_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: magnitudes and squares
	logic [31:0] ax;
	logic [31:0] ay;
	logic        valid_s1;
	logic [63:0] sq_x_s1;
	logic [63:0] sq_y_s1;

	assign ax = s_axis_tdata[31] ? (~s_axis_tdata[31:0] + 32'd1) : s_axis_tdata[31:0];
	assign ay = s_axis_tdata[63] ? (~s_axis_tdata[63:32] + 32'd1) : s_axis_tdata[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s1 <= 64'(ax) * 64'(ax);
			sq_y_s1 <= 64'(ay) * 64'(ay);
		end
	end

	// stage 2: sum of squares
	logic        valid_s2;
	logic [63:0] sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sq_x_s1 + sq_y_s1;
		end
	end

	// square root chain
	pvar_pkg::sqrt_beat_t sq_link [NS+1];

	assign sq_link[0] = '{valid: valid_s2, rem: sum_s2, root: 64'd0};

	for (genvar i = 0; i < NS; i++) begin : g_sqrt
		pvar_sqrt_cell #(.STEP(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.beat_in  (sq_link[i]),
			.beat_out (sq_link[i+1])
		);
	end

	// normalize: leading one and Q1.31 mantissa
	logic [31:0] hq;
	logic [4:0]  lead;
	logic        valid_s3;
	logic        zero_s3;
	logic [4:0]  expo_s3;
	logic [31:0] mant_s3;

	assign hq = sq_link[NS].root[31:0];

	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (hq[i]) begin
				lead = 5'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= sq_link[NS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s3 <= (hq == 32'd0);
			expo_s3 <= lead;
			mant_s3 <= hq << (5'd31 - lead);
		end
	end

	// log2 chain
	pvar_pkg::log_beat_t lg_link [NL+1];

	assign lg_link[0] = '{valid: valid_s3, zero: zero_s3, expo: expo_s3, mant: mant_s3,
		frac: '0};

	for (genvar i = 0; i < NL; i++) begin : g_log
		pvar_log_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.beat_in  (lg_link[i]),
			.beat_out (lg_link[i+1])
		);
	end

	// exponent product: t = floor(L * p / 2^15)
	logic signed [7:0]  l_whole;
	logic signed [31:0] l_val;
	logic signed [48:0] lp;
	logic               valid_s4;
	logic               zero_s4;
	logic signed [7:0]  whole_s4;
	logic [NL-1:0]      frac_s4;

	always_comb begin
		l_whole = $signed({3'b000, lg_link[NL].expo}) - 8'(FRAC_BITS);
		l_val   = {l_whole, lg_link[NL].frac};
		lp      = 49'(l_val) * $signed({1'b0, power_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= lg_link[NL].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s4  <= lg_link[NL].zero;
			whole_s4 <= lp[46:39];
			frac_s4  <= lp[38:15];
		end
	end

	// exp2 chain
	pvar_pkg::exp_beat_t ex_link [NL+1];

	assign ex_link[0] = '{valid: valid_s4, zero: zero_s4, whole: whole_s4, frac: frac_s4,
		mant: 31'h4000_0000};

	for (genvar i = 0; i < NL; i++) begin : g_exp
		pvar_exp_cell #(.K(i + 1)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.beat_in  (ex_link[i]),
			.beat_out (ex_link[i+1])
		);
	end

	// final shift to FRAC_BITS fraction bits
	logic signed [9:0] sh;
	logic [9:0]        nsh;
	logic [63:0]       y_nxt;
	logic              valid_s5;
	logic [63:0]       y_s5;

	always_comb begin
		sh    = 10'(ex_link[NL].whole) + 10'(FRAC_BITS) - 10'sd30;
		nsh   = -sh;
		y_nxt = 64'd0;
		if (ex_link[NL].zero) begin
			y_nxt = 64'd0;
		end else if (sh >= 0) begin
			if (sh < 10'sd32) begin
				y_nxt = {33'd0, ex_link[NL].mant} << sh[4:0];
			end
		end else if (nsh < 10'd63) begin
			y_nxt = {33'd0, ex_link[NL].mant} >> nsh[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= ex_link[NL].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s5 <= y_nxt;
		end
	end

	// slope partial products
	logic        valid_s6;
	logic [63:0] p0_s6;
	logic [63:0] p1_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s6 <= 64'(slope_q) * 64'(y_s5[31:0]);
			p1_s6 <= 64'(slope_q) * 64'(y_s5[63:32]);
		end
	end

	// combine, scale down, clamp to 64 bits
	logic [95:0] full;
	logic [95:0] full_sh;
	logic        valid_s7;
	logic [63:0] g_s7;

	assign full    = {32'd0, p0_s6} + {p1_s6, 32'd0};
	assign full_sh = full >> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s7 <= (full_sh[95:64] != 32'd0) ? {64{1'b1}} : full_sh[63:0];
		end
	end

	// saturating results and output register
	logic [63:0] sem_nxt;
	logic [63:0] cov_nxt;
	logic        ovf_nxt;
	logic [63:0] sem_q;
	logic [63:0] cov_q;
	logic        ovf_q;
	logic        out_valid_q;

	always_comb begin
		ovf_nxt = 1'b0;
		cov_nxt = SILL_FIX - g_s7;
		if (g_s7 > SMAX) begin
			sem_nxt = SMAX;
			cov_nxt = SMIN;
			ovf_nxt = 1'b1;
		end else if (g_s7 > SMAX - 64'(nugget_q)) begin
			sem_nxt = SMAX;
			ovf_nxt = 1'b1;
		end else begin
			sem_nxt = g_s7 + 64'(nugget_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sem_q <= sem_nxt;
			cov_q <= cov_nxt;
			ovf_q <= ovf_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, ovf_q, cov_q, sem_q};

`ifndef ASSERT_OFF
	// covariance reaches its minimum only through saturation
	a_cov_min_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && cov_q == SMIN) |-> ovf_q)
		else $error("covariance at minimum without overflow flag");

	// unsaturated semivariance never falls below the nugget
	a_sem_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !ovf_q) |-> (sem_q >= 64'(nugget_q)))
		else $error("semivariance below nugget");

	// unsaturated results share the same scaled term
	a_sum_const: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !ovf_q) |-> (sem_q + cov_q == SILL_FIX + 64'(nugget_q)))
		else $error("semivariance and covariance disagree");
`endif

endmodule
`default_nettype wire
